// File: design/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, command codes and the output tempering function for the
// MT19937 word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int KEY_DEPTH_DEF = 64;
    localparam int STATE_AW      = $clog2(STATE_WORDS);

    localparam logic [31:0] TW_MATRIX    = 32'h9908_b0df;
    localparam logic [31:0] TW_UPPER     = 32'h8000_0000;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] KEY_MULT_A   = 32'd1664525;
    localparam logic [31:0] KEY_MULT_B   = 32'd1566083941;
    localparam logic [31:0] KEY_SEED     = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    // Command codes on func
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_SEED  = 2'd1;
    localparam logic [1:0] FUNC_KEY   = 2'd2;
    localparam logic [1:0] FUNC_APPLY = 2'd3;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        begin
            y = w ^ (w >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        end
    endfunction

endpackage

// File: design/mtg_ram.sv
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mersenne_twister_generator_top.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 32-bit generator: 624-word state RAM, key store RAM, one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low;
//   func selects draw, seed, append key word or apply key, value carries the
//   seed or key word. Only a draw returns a beat: random_word is valid for one
//   cycle while word_valid is high, and the receiver must take it then.
//   Command sequences:
//   - append key word: busy stays low.
//   - draw with words left: read in ST_DR_RD, tempered in ST_DR_OUT; word_valid
//     rises together with busy dropping, so a new draw is taken only after it.
//   - draw at the end of the words: regeneration first, with three reads and
//     one write per word on the single state RAM port pair.
//   - draw before any seed: seeding (ST_SS_MUL then ST_SS_WR per word, as the
//     multiplier is registered) and then regeneration.
//   - seed: the seeding pass alone. apply key: seeding plus 1247 mixing steps
//     plus wrap writes.
//   After reset the block is idle and unseeded, with an empty key store; the
//   state RAM holds no defined data and needs no clearing pass.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top #(
    parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] value,
    output logic [31:0] random_word,
    output logic        word_valid
);

    localparam int AW = mtg_pkg::STATE_AW;
    localparam int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(mtg_pkg::STATE_WORDS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SS_INIT, ST_SS_MUL, ST_SS_WR,
        ST_RG_CUR, ST_RG_NXT, ST_RG_MID, ST_RG_WR,
        ST_KA_MUL, ST_KA_WR, ST_KA_WRAP, ST_FIN_WR,
        ST_DR_RD, ST_DR_OUT
    } state_t;

    typedef enum logic [1:0] {MODE_SEED, MODE_DRAW, MODE_KEY} mode_t;

    state_t          state_reg;
    mode_t           mode_reg;
    logic [AW-1:0]   idx_reg;       // i of seeding and key mixing, n of regeneration
    logic [AW:0]     pos_reg;       // read position, STATE_WORDS+1 means unseeded
    logic [AW:0]     step_reg;      // k of key mixing
    logic            pass_reg;
    logic [KA-1:0]   kidx_reg;
    logic [CW-1:0]   kcount_reg;
    logic [31:0]     seed_reg;
    logic [31:0]     prev_reg;
    logic [31:0]     prod_reg;
    logic            hi_reg;
    logic [30:0]     lo_reg;
    logic [31:0]     word_reg;
    logic            valid_reg;

    logic            accept;
    logic            st_we;
    logic [AW-1:0]   st_waddr;
    logic [31:0]     st_wdata;
    logic [AW-1:0]   st_raddr;
    logic [31:0]     st_rdata;
    logic            key_we;
    logic [31:0]     key_rdata;
    logic [31:0]     key_word;
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [31:0]     mix_word;
    logic [31:0]     regen_word;
    logic [31:0]     twist_y;
    logic [AW:0]     mid_sum;
    logic [AW-1:0]   mid_idx;
    logic [AW-1:0]   nxt_idx;
    logic [CW-1:0]   key_len;
    logic [CW-1:0]   kidx_inc;
    logic [AW:0]     step_inc;
    logic            step_done;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Key store: append words straight from the command beat.
    assign key_we = accept && (func == mtg_pkg::FUNC_KEY)
                    && (kcount_reg < CW'(KEY_DEPTH));

    mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH), .AW(KA)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (kcount_reg[KA-1:0]),
        .wdata (value),
        .raddr (kidx_reg),
        .rdata (key_rdata)
    );

    mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::STATE_WORDS), .AW(AW)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // An empty key store acts as a single zero word.
    assign key_len  = (kcount_reg == '0) ? CW'(1) : kcount_reg;
    assign key_word = (kcount_reg == '0) ? 32'd0 : key_rdata;
    assign kidx_inc = CW'(kidx_reg) + CW'(1);

    assign nxt_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + AW'(1);
    assign mid_sum = {1'b0, idx_reg} + (AW+1)'(mtg_pkg::MIDDLE_OFFSET);
    assign mid_idx = (mid_sum >= (AW+1)'(mtg_pkg::STATE_WORDS))
                     ? AW'(mid_sum - (AW+1)'(mtg_pkg::STATE_WORDS))
                     : mid_sum[AW-1:0];

    assign twist_y    = {hi_reg, lo_reg};
    assign regen_word = st_rdata ^ (twist_y >> 1)
                        ^ (twist_y[0] ? mtg_pkg::TW_MATRIX : 32'd0);

    assign mix_word = pass_reg ? ((st_rdata ^ prod_reg) - {{(32-AW){1'b0}}, idx_reg})
                               : ((st_rdata ^ prod_reg) + key_word
                                  + {{(32-KA){1'b0}}, kidx_reg});

    assign step_inc  = step_reg + (AW+1)'(1);
    // First mixing pass runs STATE_WORDS steps, the second one less.
    assign step_done = pass_reg ? (step_reg == (AW+1)'(mtg_pkg::STATE_WORDS - 1))
                                : (step_reg == (AW+1)'(mtg_pkg::STATE_WORDS));

    // Shared multiplier operands; the product is registered.
    always_comb
    begin
        mul_a = prev_reg ^ (prev_reg >> 30);
        case (state_reg)
            ST_SS_MUL: mul_b = mtg_pkg::INIT_MULT;
            ST_KA_MUL: mul_b = pass_reg ? mtg_pkg::KEY_MULT_B : mtg_pkg::KEY_MULT_A;
            default:   mul_b = mtg_pkg::INIT_MULT;
        endcase
    end

    // State RAM ports.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx_reg;
        st_wdata = mix_word;
        st_raddr = idx_reg;
        case (state_reg)
            ST_SS_INIT:
            begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = seed_reg;
            end
            ST_SS_WR:
            begin
                st_we    = 1'b1;
                st_wdata = prod_reg + {{(32-AW){1'b0}}, idx_reg};
            end
            ST_RG_NXT: st_raddr = nxt_idx;
            ST_RG_MID: st_raddr = mid_idx;
            ST_RG_WR:
            begin
                st_we    = 1'b1;
                st_wdata = regen_word;
            end
            ST_KA_WR:  st_we = 1'b1;
            ST_KA_WRAP:
            begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = prev_reg;
            end
            ST_FIN_WR:
            begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = mtg_pkg::TW_UPPER;
            end
            ST_DR_RD:  st_raddr = pos_reg[AW-1:0];
            default:   st_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_SEED;
            pos_reg    <= (AW+1)'(mtg_pkg::STATE_WORDS + 1);
            kcount_reg <= '0;
            valid_reg  <= 1'b0;
            idx_reg    <= '0;
            step_reg   <= '0;
            pass_reg   <= 1'b0;
            kidx_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (func)
                            mtg_pkg::FUNC_DRAW:
                            begin
                                if (pos_reg == (AW+1)'(mtg_pkg::STATE_WORDS))
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= ST_RG_CUR;
                                end
                                else if (pos_reg > (AW+1)'(mtg_pkg::STATE_WORDS))
                                begin
                                    seed_reg  <= mtg_pkg::DEFAULT_SEED;
                                    mode_reg  <= MODE_DRAW;
                                    state_reg <= ST_SS_INIT;
                                end
                                else
                                begin
                                    state_reg <= ST_DR_RD;
                                end
                            end
                            mtg_pkg::FUNC_SEED:
                            begin
                                seed_reg  <= value;
                                mode_reg  <= MODE_SEED;
                                state_reg <= ST_SS_INIT;
                            end
                            mtg_pkg::FUNC_KEY:
                            begin
                                if (key_we)
                                begin
                                    kcount_reg <= kcount_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                                seed_reg  <= mtg_pkg::KEY_SEED;
                                mode_reg  <= MODE_KEY;
                                state_reg <= ST_SS_INIT;
                            end
                        endcase
                    end
                end
                ST_SS_INIT:
                begin
                    prev_reg  <= seed_reg;
                    idx_reg   <= AW'(1);
                    state_reg <= ST_SS_MUL;
                end
                ST_SS_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_SS_WR;
                end
                ST_SS_WR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        pos_reg <= (AW+1)'(mtg_pkg::STATE_WORDS);
                        case (mode_reg)
                            MODE_DRAW:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_RG_CUR;
                            end
                            MODE_KEY:
                            begin
                                // word 0 still holds the seed
                                prev_reg  <= seed_reg;
                                idx_reg   <= AW'(1);
                                kidx_reg  <= '0;
                                step_reg  <= '0;
                                pass_reg  <= 1'b0;
                                state_reg <= ST_KA_MUL;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                    else
                    begin
                        prev_reg  <= st_wdata;
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_SS_MUL;
                    end
                end
                ST_RG_CUR: state_reg <= ST_RG_NXT;
                ST_RG_NXT:
                begin
                    hi_reg    <= st_rdata[31];
                    state_reg <= ST_RG_MID;
                end
                ST_RG_MID:
                begin
                    lo_reg    <= st_rdata[30:0];
                    state_reg <= ST_RG_WR;
                end
                ST_RG_WR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        pos_reg   <= '0;
                        state_reg <= ST_DR_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_RG_CUR;
                    end
                end
                ST_KA_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_KA_WR;
                end
                ST_KA_WR:
                begin
                    prev_reg <= mix_word;
                    kidx_reg <= (kidx_inc >= key_len) ? '0 : kidx_inc[KA-1:0];
                    if (idx_reg == LAST_IDX)
                    begin
                        step_reg  <= step_inc;
                        state_reg <= ST_KA_WRAP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                        // step_done looks at the count before this step
                        if (pass_reg ? (step_inc == (AW+1)'(mtg_pkg::STATE_WORDS - 1))
                                     : (step_inc == (AW+1)'(mtg_pkg::STATE_WORDS)))
                        begin
                            if (pass_reg)
                            begin
                                step_reg  <= step_inc;
                                state_reg <= ST_FIN_WR;
                            end
                            else
                            begin
                                pass_reg  <= 1'b1;
                                step_reg  <= '0;
                                state_reg <= ST_KA_MUL;
                            end
                        end
                        else
                        begin
                            step_reg  <= step_inc;
                            state_reg <= ST_KA_MUL;
                        end
                    end
                end
                ST_KA_WRAP:
                begin
                    idx_reg <= AW'(1);
                    if (step_done)
                    begin
                        if (pass_reg)
                        begin
                            state_reg <= ST_FIN_WR;
                        end
                        else
                        begin
                            pass_reg  <= 1'b1;
                            step_reg  <= '0;
                            state_reg <= ST_KA_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_KA_MUL;
                    end
                end
                ST_FIN_WR:
                begin
                    pos_reg    <= (AW+1)'(mtg_pkg::STATE_WORDS);
                    kcount_reg <= '0;
                    state_reg  <= ST_IDLE;
                end
                ST_DR_RD: state_reg <= ST_DR_OUT;
                ST_DR_OUT:
                begin
                    word_reg  <= mtg_pkg::temper(st_rdata);
                    valid_reg <= 1'b1;
                    pos_reg   <= pos_reg + (AW+1)'(1);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign random_word = word_reg;
    assign word_valid  = valid_reg;

endmodule

// File: design/mtg_checker.sv
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks on command and result beats of the generator.
// ----------------------------------------------------------------------------
module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  func,
    input logic        word_valid
);

    logic accept;
    assign accept = start && !busy;

    // A result beat lasts one cycle.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |=> !word_valid)
        else $error("word_valid held for more than one cycle");

    // The result leaves with the block back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> !busy)
        else $error("result beat while busy");

    // Every command other than a key append occupies the block.
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func != mtg_pkg::FUNC_KEY) |=> busy)
        else $error("command accepted without going busy");

    // A key append neither stalls nor produces a result.
    a_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == mtg_pkg::FUNC_KEY) |=> (!busy && !word_valid))
        else $error("key append disturbed the block");

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .word_valid (word_valid)
);

// File: sim/tb_mersenne_twister_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator_top
// Self-checking bench for the MT19937 word generator. Directed commands run
// first, then a key store overflow run and random commands. Each draw is
// predicted by a behavioral twister in the bench and compared with the beat.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_top;

    localparam int KEY_DEPTH    = mtg_pkg::KEY_DEPTH_DEF;
    localparam int RANDOM_CMDS  = 1180;
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [31:0] value;
    logic [31:0] random_word;
    logic        word_valid;

    // Model state of the generator
    logic [31:0] mt_words [mtg_pkg::STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] key_store [KEY_DEPTH];
    int unsigned key_fill;

    // Words still owed by the block, oldest first
    logic [31:0] pending_words [$];
    int          fail_count;

    // Directed command table; known_word is used only where has_known is set
    typedef struct {
        logic [1:0]  op;
        logic [31:0] data;
        bit          has_known;
        logic [31:0] known_word;
    } cmd_row_t;

    cmd_row_t directed_cmds [$];

    mersenne_twister_generator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .random_word(random_word),
        .word_valid (word_valid)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void mt_seed_single(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < mtg_pkg::STATE_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = mtg_pkg::INIT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = mtg_pkg::STATE_WORDS;
    endfunction

    function automatic void mt_seed_key();
        int unsigned len;
        int unsigned i;
        int unsigned j;
        int          k;
        logic [31:0] p;
        logic [31:0] kw;
        i = 1;
        j = 0;
        len = key_fill;
        mt_seed_single(mtg_pkg::KEY_SEED);
        if (len == 0)
        begin
            key_store[0] = '0;
            len = 1;
        end
        k = (len > mtg_pkg::STATE_WORDS) ? len : mtg_pkg::STATE_WORDS;
        for (; k > 0; k--)
        begin
            p  = mt_words[i-1];
            kw = key_store[j % KEY_DEPTH];
            mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::KEY_MULT_A))
                          + kw + 32'(j);
            i++;
            j++;
            if (i >= mtg_pkg::STATE_WORDS)
            begin
                mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
                i = 1;
            end
            if (j >= len)
                j = 0;
        end
        for (k = mtg_pkg::STATE_WORDS - 1; k > 0; k--)
        begin
            p = mt_words[i-1];
            mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::KEY_MULT_B))
                          - 32'(i);
            i++;
            if (i >= mtg_pkg::STATE_WORDS)
            begin
                mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
                i = 1;
            end
        end
        mt_words[0] = mtg_pkg::TW_UPPER;
        mt_pos = mtg_pkg::STATE_WORDS;
        key_fill = 0;
    endfunction

    function automatic void mt_regenerate();
        logic [31:0] y;
        for (int n = 0; n < mtg_pkg::STATE_WORDS; n++)
        begin
            y = (mt_words[n] & mtg_pkg::TW_UPPER)
                | (mt_words[(n+1) % mtg_pkg::STATE_WORDS] & ~mtg_pkg::TW_UPPER);
            mt_words[n] = mt_words[(n + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_WORDS]
                        ^ (y >> 1) ^ (y[0] ? mtg_pkg::TW_MATRIX : 32'h0);
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] mt_next_word();
        logic [31:0] y;
        if (mt_pos >= mtg_pkg::STATE_WORDS)
        begin
            if (mt_pos != mtg_pkg::STATE_WORDS)
                mt_seed_single(mtg_pkg::DEFAULT_SEED);
            mt_regenerate();
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Advance the model for one accepted command; return the owed word if any
    function automatic bit mt_apply_cmd(input logic [1:0] op, input logic [31:0] data,
                                        output logic [31:0] word);
        word = '0;
        case (op)
            mtg_pkg::FUNC_DRAW:
            begin
                word = mt_next_word();
                return 1'b1;
            end
            mtg_pkg::FUNC_SEED:
                mt_seed_single(data);
            mtg_pkg::FUNC_KEY:
                if (key_fill < KEY_DEPTH)
                begin
                    key_store[key_fill] = data;
                    key_fill++;
                end
            default:
                mt_seed_key();
        endcase
        return 1'b0;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input logic [1:0] op, input logic [31:0] data,
                           input bit has_known, input logic [31:0] known_word);
        cmd_row_t row;
        row.op         = op;
        row.data       = data;
        row.has_known  = has_known;
        row.known_word = known_word;
        directed_cmds  = {directed_cmds, row};
    endtask

    // ------------------------------------------------------------------
    // Command driver: issue one beat at the falling edge, hold until taken
    // ------------------------------------------------------------------
    task automatic issue_cmd(input logic [1:0] op, input logic [31:0] data,
                             input bit has_known, input logic [31:0] known_word);
        int          gap;
        logic [31:0] word;
        bit          owes;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        start = 1'b1;
        func  = op;
        value = data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // beat taken at this edge; predict before the word can appear
        owes = mt_apply_cmd(op, data, word);
        if (owes)
        begin
            if (has_known && word !== known_word)
            begin
                $error("predictor random_word: expected %h, actual %h", known_word, word);
                fail_count++;
            end
            pending_words = {pending_words, word};
        end
        @(negedge clk);
        start = 1'b0;
        func  = 2'($urandom());
        value = $urandom();
    endtask

    // ------------------------------------------------------------------
    // Result monitor: every word beat must match the oldest owed word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && word_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $error("random_word: expected none, actual %h", random_word);
                fail_count++;
            end
            else
            begin
                logic [31:0] exp_word;
                exp_word = pending_words.pop_front();
                if (random_word !== exp_word)
                begin
                    $error("random_word: expected %h, actual %h", exp_word, random_word);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Drain enough draws to run past a regeneration now and then
    task automatic draw_burst(input int count);
        for (int n = 0; n < count; n++)
            issue_cmd(mtg_pkg::FUNC_DRAW, $urandom(), 1'b0, '0);
    endtask

    // Safety limit: slow runs with many regenerations still fit well inside
    initial
    begin
        #400ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int       wait_cycles;
        int       sel;
        cmd_row_t row;
        fail_count = 0;
        start  = 1'b0;
        func   = mtg_pkg::FUNC_DRAW;
        value  = '0;
        rst_n  = 1'b0;
        foreach (mt_words[n]) mt_words[n] = '0;
        foreach (key_store[n]) key_store[n] = '0;
        mt_pos   = mtg_pkg::STATE_WORDS + 1;
        key_fill = 0;

        // Directed table: first draws of the default seed are well known
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b1, 32'd3499211612);
        add_row(mtg_pkg::FUNC_DRAW,  32'hffff_ffff, 1'b1, 32'd581869302);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b1, 32'd3890346734);
        add_row(mtg_pkg::FUNC_SEED,  32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_SEED,  32'hffff_ffff, 1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_SEED,  mtg_pkg::DEFAULT_SEED, 1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b1, 32'd3499211612);
        // empty key store: single zero key word
        add_row(mtg_pkg::FUNC_APPLY, 32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b0, '0);
        // the classic four-word key
        add_row(mtg_pkg::FUNC_KEY,   32'h123,       1'b0, '0);
        add_row(mtg_pkg::FUNC_KEY,   32'h234,       1'b0, '0);
        add_row(mtg_pkg::FUNC_KEY,   32'h345,       1'b0, '0);
        add_row(mtg_pkg::FUNC_KEY,   32'h456,       1'b0, '0);
        // a seed leaves the key store alone
        add_row(mtg_pkg::FUNC_SEED,  32'h1,         1'b0, '0);
        add_row(mtg_pkg::FUNC_APPLY, 32'hffff_ffff, 1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_KEY,   32'hffff_ffff, 1'b0, '0);
        add_row(mtg_pkg::FUNC_KEY,   32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_APPLY, 32'h0,         1'b0, '0);
        add_row(mtg_pkg::FUNC_DRAW,  32'h0,         1'b0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_cmds[n])
        begin
            row = directed_cmds[n];
            issue_cmd(row.op, row.data, row.has_known, row.known_word);
        end

        // Key store overflow: fill past capacity, then apply
        for (int n = 0; n < KEY_DEPTH + 6; n++)
            issue_cmd(mtg_pkg::FUNC_KEY, rand_word(), 1'b0, '0);
        issue_cmd(mtg_pkg::FUNC_APPLY, $urandom(), 1'b0, '0);
        draw_burst(mtg_pkg::STATE_WORDS + 4);

        // Random part: mostly draws, with occasional reseeds and key runs
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 88)
                issue_cmd(mtg_pkg::FUNC_DRAW, $urandom(), 1'b0, '0);
            else if (sel < 91)
                issue_cmd(mtg_pkg::FUNC_SEED, rand_word(), 1'b0, '0);
            else if (sel < 98)
                issue_cmd(mtg_pkg::FUNC_KEY, rand_word(), 1'b0, '0);
            else
                issue_cmd(mtg_pkg::FUNC_APPLY, $urandom(), 1'b0, '0);
        end

        // Wait for owed words, then a short settle
        wait_cycles = 0;
        while (pending_words.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
design/mtg_pkg.sv
design/mtg_ram.sv
design/mersenne_twister_generator_top.sv
design/mtg_checker.sv
sim/tb_mersenne_twister_generator_top.sv
